@@ hdl/nmea_gga_pkg.sv @@
// Shared types, character codes and result codes for the GGA field extractor.
// Depends on nothing; the top level refers to it by scoped names.
package nmea_gga_pkg;

    // Longest sentence, counting the '$' but not the terminator
    localparam int MAX_SENTENCE_LEN = 1024;
    localparam int POS_W            = $clog2(MAX_SENTENCE_LEN + 1);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [2:0]       count_t;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;

    // Sentence layout
    localparam int     HEADER_FIRST = 3;
    localparam int     HEADER_LAST  = 5;
    localparam int     HEADER_END   = 6;
    localparam count_t NO_FIX_RUN   = 3'd5;
    localparam count_t COMMA_MAX    = 3'd7;
    localparam count_t FIELD_FIRST  = 3'd1;
    localparam count_t FIELD_LAST   = 3'd5;

    typedef enum logic
    {
        KIND_FIELD   = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        VERDICT_ACCEPTED = 2'd0,
        VERDICT_NOT_GGA  = 2'd1,
        VERDICT_NO_FIX   = 2'd2,
        VERDICT_OVERFLOW = 2'd3
    } verdict_t;

endpackage

@@ hdl/nmea_gga_field_extractor.sv @@
// Latency: a result is valid in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle; a new byte is taken while the held result is taken.
// The only stall is a held result that the output side does not take.
// Reset (rst_n low, asynchronous) leaves the block outside any sentence with all
// sentence state cleared and no result pending.
// Depends on nmea_gga_pkg.
module nmea_gga_field_extractor
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [2:0] field_number,
    output logic [7:0] field_char,
    output logic [1:0] verdict
);

    // Sentence state
    logic                in_sentence_reg, in_sentence_next;
    nmea_gga_pkg::pos_t  char_position_reg, char_position_next;
    nmea_gga_pkg::count_t comma_count_reg, comma_count_next;
    nmea_gga_pkg::count_t comma_run_reg, comma_run_next;
    logic                header_match_reg, header_match_next;
    logic                no_fix_seen_reg, no_fix_seen_next;
    logic                overflowed_reg, overflowed_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    nmea_gga_pkg::kind_t    kind_reg, kind_next;
    logic [2:0]             field_number_reg, field_number_next;
    logic [7:0]             field_char_reg, field_char_next;
    nmea_gga_pkg::verdict_t verdict_reg, verdict_next;

    logic       accept;
    logic       emit;
    logic       header_bad;
    logic [7:0] header_char;

    // Take a byte whenever the result register is free or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Expected header character at the current position
    assign header_char = (char_position_reg == nmea_gga_pkg::POS_W'(3)
                          || char_position_reg == nmea_gga_pkg::POS_W'(4))
                         ? nmea_gga_pkg::CH_G : nmea_gga_pkg::CH_A;
    assign header_bad  = char_position_reg >= nmea_gga_pkg::POS_W'(nmea_gga_pkg::HEADER_FIRST)
                         && char_position_reg <= nmea_gga_pkg::POS_W'(nmea_gga_pkg::HEADER_LAST)
                         && rx_byte != header_char;

    // Advance sentence state and build the result for one byte
    always_comb
    begin
        in_sentence_next   = in_sentence_reg;
        char_position_next = char_position_reg;
        comma_count_next   = comma_count_reg;
        comma_run_next     = comma_run_reg;
        header_match_next  = header_match_reg;
        no_fix_seen_next   = no_fix_seen_reg;
        overflowed_next    = overflowed_reg;
        emit               = 1'b0;
        kind_next          = nmea_gga_pkg::KIND_FIELD;
        field_number_next  = 3'd0;
        field_char_next    = 8'd0;
        verdict_next       = nmea_gga_pkg::VERDICT_ACCEPTED;

        if (accept)
        begin
            if (rx_byte == nmea_gga_pkg::CH_DOLLAR)
            begin
                // Open or restart a sentence
                in_sentence_next   = 1'b1;
                char_position_next = nmea_gga_pkg::POS_W'(1);
                comma_count_next   = '0;
                comma_run_next     = '0;
                header_match_next  = 1'b1;
                no_fix_seen_next   = 1'b0;
                overflowed_next    = 1'b0;
            end
            else if (in_sentence_reg)
            begin
                if (rx_byte == nmea_gga_pkg::CH_CR || rx_byte == nmea_gga_pkg::CH_LF)
                begin
                    // Close the sentence with its verdict
                    emit      = 1'b1;
                    kind_next = nmea_gga_pkg::KIND_VERDICT;
                    if (!header_match_reg
                        || char_position_reg < nmea_gga_pkg::POS_W'(nmea_gga_pkg::HEADER_END))
                        verdict_next = nmea_gga_pkg::VERDICT_NOT_GGA;
                    else if (overflowed_reg)
                        verdict_next = nmea_gga_pkg::VERDICT_OVERFLOW;
                    else if (no_fix_seen_reg)
                        verdict_next = nmea_gga_pkg::VERDICT_NO_FIX;
                    else
                        verdict_next = nmea_gga_pkg::VERDICT_ACCEPTED;
                    in_sentence_next   = 1'b0;
                    char_position_next = '0;
                    comma_count_next   = '0;
                    comma_run_next     = '0;
                    header_match_next  = 1'b1;
                    no_fix_seen_next   = 1'b0;
                    overflowed_next    = 1'b0;
                end
                else if (char_position_reg
                         >= nmea_gga_pkg::POS_W'(nmea_gga_pkg::MAX_SENTENCE_LEN))
                begin
                    // Drop bytes past the maximum length
                    overflowed_next = 1'b1;
                end
                else
                begin
                    char_position_next = char_position_reg + nmea_gga_pkg::POS_W'(1);
                    if (header_bad)
                        header_match_next = 1'b0;

                    if (rx_byte == nmea_gga_pkg::CH_COMMA)
                    begin
                        // Count commas and track runs of empty fields
                        if (comma_count_reg < nmea_gga_pkg::COMMA_MAX)
                            comma_count_next = comma_count_reg + 3'd1;
                        if (comma_run_reg < nmea_gga_pkg::NO_FIX_RUN)
                            comma_run_next = comma_run_reg + 3'd1;
                        if (comma_run_next >= nmea_gga_pkg::NO_FIX_RUN)
                            no_fix_seen_next = 1'b1;
                    end
                    else
                    begin
                        comma_run_next = '0;
                        // Emit characters of fields one to five
                        if (header_match_next
                            && char_position_reg
                               >= nmea_gga_pkg::POS_W'(nmea_gga_pkg::HEADER_END)
                            && comma_count_reg >= nmea_gga_pkg::FIELD_FIRST
                            && comma_count_reg <= nmea_gga_pkg::FIELD_LAST)
                        begin
                            emit              = 1'b1;
                            field_number_next = comma_count_reg - 3'd1;
                            field_char_next   = rx_byte;
                        end
                    end
                end
            end
        end

        // Hold the result until transferred
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg   <= 1'b0;
            char_position_reg <= '0;
            comma_count_reg   <= '0;
            comma_run_reg     <= '0;
            header_match_reg  <= 1'b1;
            no_fix_seen_reg   <= 1'b0;
            overflowed_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            in_sentence_reg   <= in_sentence_next;
            char_position_reg <= char_position_next;
            comma_count_reg   <= comma_count_next;
            comma_run_reg     <= comma_run_next;
            header_match_reg  <= header_match_next;
            no_fix_seen_reg   <= no_fix_seen_next;
            overflowed_reg    <= overflowed_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg         <= kind_next;
            field_number_reg <= field_number_next;
            field_char_reg   <= field_char_next;
            verdict_reg      <= verdict_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign field_number = field_number_reg;
    assign field_char   = field_char_reg;
    assign verdict      = verdict_reg;

    // Position never runs past the maximum length
    assert property (@(posedge clk) disable iff (!rst_n)
        char_position_reg <= nmea_gga_pkg::POS_W'(nmea_gga_pkg::MAX_SENTENCE_LEN))
        else $error("char_position past maximum sentence length");

    // Outside a sentence the position, comma count, overflow and no-fix flags are clear
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_sentence_reg |-> (char_position_reg == '0 && comma_count_reg == '0
                              && !overflowed_reg && !no_fix_seen_reg))
        else $error("sentence state not clear outside a sentence");

    // A '$' transfer opens a sentence at position one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx_byte == nmea_gga_pkg::CH_DOLLAR)
        |=> (in_sentence_reg && char_position_reg == nmea_gga_pkg::POS_W'(1)))
        else $error("dollar did not open a sentence");

    // Field results carry a field number of at most four and no verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == nmea_gga_pkg::KIND_FIELD)
        |-> (field_number_reg <= 3'd4 && verdict_reg == nmea_gga_pkg::VERDICT_ACCEPTED))
        else $error("malformed field result");

    // Comma run saturates at the no-fix length
    assert property (@(posedge clk) disable iff (!rst_n)
        comma_run_reg <= nmea_gga_pkg::NO_FIX_RUN)
        else $error("comma run past saturation");

endmodule
